// ----- design/afr_pkg.sv -----
// Shared types, codes and the CRC-16 byte update for the addressed frame receiver.
// Depends on nothing; used by the frame state machine, the top level and the checker.

package afr_pkg;

    localparam logic [7:0]  FRAME_HEADER = 8'h55;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  IDLE_MAX     = 8'hFF;

    localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [2:0] KIND_GOOD      = 3'd1;
    localparam logic [2:0] KIND_BAD_CRC   = 3'd2;
    localparam logic [2:0] KIND_EMPTY     = 3'd3;
    localparam logic [2:0] KIND_ABANDONED = 3'd4;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [7:0]  payload;
        logic [7:0]  address;
        logic [15:0] length;
    } afr_result_t;

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

// ----- design/afr_frame_fsm.sv -----
// Frame state machine: header hunt, address check, length, payload, CRC check, idle timeout.
// Depends on afr_pkg for result codes, the result struct and the CRC byte update.

module afr_frame_fsm
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                req_type,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          node_address,
    input  logic [7:0]          idle_tick_limit,
    output afr_pkg::afr_result_t result
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_ADDR    = 3'd1;
    localparam logic [2:0] PH_LEN_HI  = 3'd2;
    localparam logic [2:0] PH_LEN_LO  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CRC_HI  = 3'd5;
    localparam logic [2:0] PH_CRC_LO  = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;
    logic [7:0]  idle_reg, idle_next;
    logic [7:0]  addr_reg, addr_next;

    logic [15:0] crc_fed;
    logic [15:0] left_dec;

    assign crc_fed  = afr_pkg::crc16_feed(crc_reg, rx_byte);
    assign left_dec = left_reg - 16'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        left_next      = left_reg;
        length_next    = length_reg;
        crc_next       = crc_reg;
        crc_hi_next    = crc_hi_reg;
        idle_next      = idle_reg;
        addr_next      = addr_reg;
        result.valid   = 1'b0;
        result.kind    = afr_pkg::KIND_PAYLOAD;
        result.payload = 8'h00;
        result.address = addr_reg;
        result.length  = length_reg;

        if (req_type == afr_pkg::REQ_TICK)
        begin
            if (idle_reg != afr_pkg::IDLE_MAX)
                idle_next = idle_reg + 8'd1;
            if (phase_reg != PH_HUNT && idle_next > idle_tick_limit)
            begin
                phase_next   = PH_HUNT;
                result.valid = 1'b1;
                result.kind  = afr_pkg::KIND_ABANDONED;
            end
        end
        else
        begin
            idle_next = 8'h00;
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == afr_pkg::FRAME_HEADER)
                    begin
                        crc_next    = afr_pkg::crc16_feed(afr_pkg::CRC_INIT, rx_byte);
                        addr_next   = 8'h00;
                        length_next = 16'h0000;
                        left_next   = 16'h0000;
                        crc_hi_next = 8'h00;
                        phase_next  = PH_ADDR;
                    end
                end
                PH_ADDR:
                begin
                    if (rx_byte != node_address)
                        phase_next = PH_HUNT;
                    else
                    begin
                        addr_next  = rx_byte;
                        crc_next   = crc_fed;
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    length_next = {rx_byte, 8'h00};
                    crc_next    = crc_fed;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_next = {length_reg[15:8], rx_byte};
                    left_next   = {length_reg[15:8], rx_byte};
                    crc_next    = crc_fed;
                    phase_next  = ({length_reg[15:8], rx_byte} == 16'h0000) ? PH_CRC_HI
                                                                           : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    crc_next       = crc_fed;
                    left_next      = left_dec;
                    if (left_dec == 16'h0000)
                        phase_next = PH_CRC_HI;
                    result.valid   = 1'b1;
                    result.kind    = afr_pkg::KIND_PAYLOAD;
                    result.payload = rx_byte;
                end
                PH_CRC_HI:
                begin
                    crc_hi_next = rx_byte;
                    phase_next  = PH_CRC_LO;
                end
                default:
                begin
                    phase_next   = PH_HUNT;
                    result.valid = 1'b1;
                    if (length_reg == 16'h0000)
                        result.kind = afr_pkg::KIND_EMPTY;
                    else if ({crc_hi_reg, rx_byte} == crc_reg)
                        result.kind = afr_pkg::KIND_GOOD;
                    else
                        result.kind = afr_pkg::KIND_BAD_CRC;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            left_reg   <= 16'h0000;
            length_reg <= 16'h0000;
            crc_reg    <= afr_pkg::CRC_INIT;
            crc_hi_reg <= 8'h00;
            idle_reg   <= 8'h00;
            addr_reg   <= 8'h00;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            length_reg <= length_next;
            crc_reg    <= crc_next;
            crc_hi_reg <= crc_hi_next;
            idle_reg   <= idle_next;
            addr_reg   <= addr_next;
        end
    end

endmodule

// ----- design/addressed_frame_receiver_crc16_unit.sv -----
// Top level of the addressed frame receiver: configuration registers, input and result registers.
// Depends on afr_pkg and instantiates afr_frame_fsm.

// The receiver takes one transfer per clock cycle while in_stall is low, bus bytes and idle
// ticks alike, and passes each result through the input register and then the result register,
// with the frame state and the bytewise CRC-16 update between them. While a result waits to be
// taken, one more input transfer is held in the input register; only then does in_stall rise.
// The user must write configuration through cfg_write only when the block is idle; the block
// itself does not enforce this. Index 0 is the node address and index 1 the idle tick limit.

module addressed_frame_receiver_crc16_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  frame_address,
    output logic [15:0] frame_length
);

    localparam logic CFG_NODE_ADDRESS = 1'b0;
    localparam logic CFG_IDLE_LIMIT   = 1'b1;

    logic [7:0]  node_address_reg;
    logic [7:0]  idle_limit_reg;
    logic        in_full_reg;
    logic        in_type_reg;
    logic [7:0]  in_byte_reg;
    logic        out_full_reg;
    afr_pkg::afr_result_t out_reg;
    afr_pkg::afr_result_t step_result;
    logic        advance;
    logic        step;
    logic        in_take;

    assign advance  = !out_full_reg || !out_stall;
    assign step     = in_full_reg && advance;
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg <= 8'h00;
            idle_limit_reg   <= 8'd3;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_NODE_ADDRESS: node_address_reg <= cfg_data;
                CFG_IDLE_LIMIT:   idle_limit_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_take)
            in_full_reg <= 1'b1;
        else if (step)
            in_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_type_reg <= req_type;
            in_byte_reg <= rx_byte;
        end
    end

    afr_frame_fsm u_fsm
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .req_type        (in_type_reg),
        .rx_byte         (in_byte_reg),
        .node_address    (node_address_reg),
        .idle_tick_limit (idle_limit_reg),
        .result          (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (advance)
            out_full_reg <= step && step_result.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step && step_result.valid)
            out_reg <= step_result;
    end

    assign out_valid     = out_full_reg;
    assign result_kind   = out_reg.kind;
    assign payload_byte  = out_reg.payload;
    assign frame_address = out_reg.address;
    assign frame_length  = out_reg.length;

endmodule

// ----- design/afr_checker.sv -----
// Port-level checker for the addressed frame receiver, bound to the top level.
// Depends on afr_pkg for the result codes.

module afr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  result_kind,
    input logic [7:0]  payload_byte,
    input logic [15:0] frame_length
);

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Result transfer withdrawn while stalled.");

    a_kind_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(result_kind) && $stable(payload_byte))
        else $error("Stalled result changed.");

    a_status_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != afr_pkg::KIND_PAYLOAD |-> payload_byte == 8'h00)
        else $error("Status result carries a payload byte.");

    a_payload_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == afr_pkg::KIND_PAYLOAD |-> frame_length != 16'h0000)
        else $error("Payload byte from a frame of zero length.");

    a_empty_zero_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == afr_pkg::KIND_GOOD || result_kind == afr_pkg::KIND_BAD_CRC)
        |-> frame_length != 16'h0000)
        else $error("CRC status reported for a frame of zero length.");

endmodule

bind addressed_frame_receiver_crc16_unit afr_checker u_afr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .payload_byte (payload_byte),
    .frame_length (frame_length)
);

// ----- sim/tb_top.sv -----
// Self-checking testbench for addressed_frame_receiver_crc16_unit: directed and random bus
// traffic, checked against a behavioural frame receiver with its own CRC-16 and phase tracking.
// Depends on afr_pkg and the receiver RTL only.
`timescale 1ns / 1ps

module tb_top;

    localparam logic REG_NODE_ADDRESS = 1'b0;
    localparam logic REG_IDLE_LIMIT   = 1'b1;
    localparam int   HOLD_CYCLES      = 60;
    localparam int   SETTLE_CYCLES    = 4;
    localparam int   WATCHDOG_LIMIT   = 1000;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_ADDR,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_PAYLOAD,
        ST_CRC_HI,
        ST_CRC_LO
    } rx_state_t;

    typedef struct packed {
        logic       req;
        logic [7:0] data;
    } bus_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload;
        logic [7:0]  address;
        logic [15:0] length;
    } frame_event_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = REG_NODE_ADDRESS;
    logic [7:0]  cfg_data  = 8'h00;
    logic        in_valid  = 1'b0;
    logic        req_type  = afr_pkg::REQ_BYTE;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [2:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_address;
    logic [15:0] frame_length;

    logic        steady   = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    int          hold_left = 0;

    bus_item_t    pending_items[$];
    frame_event_t awaited_events[$];
    int unsigned  items_queued = 0;
    int unsigned  items_taken  = 0;
    int unsigned  error_count  = 0;
    bus_item_t    drv_next;
    frame_event_t drv_event;

    logic [7:0]  own_addr      = 8'h00;
    logic [7:0]  tick_limit    = 8'd3;
    rx_state_t   rx_state      = ST_HUNT;
    logic [15:0] bytes_left    = 16'h0000;
    logic [15:0] announced_len = 16'h0000;
    logic [15:0] crc_acc       = afr_pkg::CRC_INIT;
    logic [7:0]  crc_hi_seen   = 8'h00;
    logic [7:0]  idle_count    = 8'h00;
    logic [7:0]  cur_addr      = 8'h00;

    addressed_frame_receiver_crc16_unit u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .payload_byte  (payload_byte),
        .frame_address (frame_address),
        .frame_length  (frame_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ b[i];
            r  = r >> 1;
            if (fb)
                r = r ^ afr_pkg::CRC_POLY;
        end
        return r;
    endfunction

    function automatic bit receive_item(input logic is_tick, input logic [7:0] b,
                                        output frame_event_t ev);
        bit         emit_now;
        logic [2:0] k;
        emit_now = 1'b0;
        k        = afr_pkg::KIND_PAYLOAD;
        ev       = '0;
        if (is_tick == afr_pkg::REQ_TICK)
        begin
            if (idle_count != afr_pkg::IDLE_MAX)
                idle_count = idle_count + 8'd1;
            if (rx_state != ST_HUNT && idle_count > tick_limit)
            begin
                rx_state = ST_HUNT;
                emit_now = 1'b1;
                k        = afr_pkg::KIND_ABANDONED;
            end
        end
        else
        begin
            idle_count = 8'h00;
            case (rx_state)
                ST_HUNT:
                begin
                    if (b == afr_pkg::FRAME_HEADER)
                    begin
                        crc_acc       = crc16_step(afr_pkg::CRC_INIT, b);
                        cur_addr      = 8'h00;
                        announced_len = 16'h0000;
                        bytes_left    = 16'h0000;
                        crc_hi_seen   = 8'h00;
                        rx_state      = ST_ADDR;
                    end
                end
                ST_ADDR:
                begin
                    if (b != own_addr)
                        rx_state = ST_HUNT;
                    else
                    begin
                        cur_addr = b;
                        crc_acc  = crc16_step(crc_acc, b);
                        rx_state = ST_LEN_HI;
                    end
                end
                ST_LEN_HI:
                begin
                    announced_len = {b, 8'h00};
                    crc_acc       = crc16_step(crc_acc, b);
                    rx_state      = ST_LEN_LO;
                end
                ST_LEN_LO:
                begin
                    announced_len[7:0] = b;
                    bytes_left         = announced_len;
                    crc_acc            = crc16_step(crc_acc, b);
                    rx_state           = (bytes_left == 16'h0000) ? ST_CRC_HI : ST_PAYLOAD;
                end
                ST_PAYLOAD:
                begin
                    crc_acc    = crc16_step(crc_acc, b);
                    bytes_left = bytes_left - 16'd1;
                    if (bytes_left == 16'h0000)
                        rx_state = ST_CRC_HI;
                    emit_now   = 1'b1;
                    k          = afr_pkg::KIND_PAYLOAD;
                    ev.payload = b;
                end
                ST_CRC_HI:
                begin
                    crc_hi_seen = b;
                    rx_state    = ST_CRC_LO;
                end
                default:
                begin
                    rx_state = ST_HUNT;
                    emit_now = 1'b1;
                    if (announced_len == 16'h0000)
                        k = afr_pkg::KIND_EMPTY;
                    else if ({crc_hi_seen, b} == crc_acc)
                        k = afr_pkg::KIND_GOOD;
                    else
                        k = afr_pkg::KIND_BAD_CRC;
                end
            endcase
        end
        ev.kind    = k;
        ev.address = cur_addr;
        ev.length  = announced_len;
        return emit_now;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_result();
        frame_event_t want;
        if (awaited_events.size() == 0)
            report_mismatch($sformatf("unexpected result kind %0d payload %h address %h length %h",
                                      result_kind, payload_byte, frame_address, frame_length));
        else
        begin
            want = awaited_events.pop_front();
            if (result_kind !== want.kind || payload_byte !== want.payload ||
                frame_address !== want.address || frame_length !== want.length)
                report_mismatch($sformatf(
                    "kind %0d/%0d payload %h/%h address %h/%h length %h/%h (got/expected)",
                    result_kind, want.kind, payload_byte, want.payload,
                    frame_address, want.address, frame_length, want.length));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= afr_pkg::REQ_BYTE;
            rx_byte  <= 8'h00;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (receive_item(req_type, rx_byte, drv_event))
                    awaited_events.push_back(drv_event);
                items_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 19))
                begin
                    drv_next = pending_items.pop_front();
                    in_valid <= 1'b1;
                    req_type <= drv_next.req;
                    rx_byte  <= drv_next.data;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_ack  <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (hold_req != hold_ack)
            begin
                hold_ack  <= hold_req;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !steady && ($urandom_range(99) < 19);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: errors");
        $finish;
    end

    task automatic queue_item(input logic req, input logic [7:0] data);
        pending_items.push_back('{req, data});
        items_queued++;
    endtask

    task automatic queue_byte(input logic [7:0] b);
        queue_item(afr_pkg::REQ_BYTE, b);
    endtask

    task automatic queue_gap(input int unsigned n);
        repeat (n)
            queue_item(afr_pkg::REQ_TICK, 8'($urandom_range(255)));
    endtask

    task automatic queue_frame_byte(input logic [7:0] b, inout logic [15:0] crc, input bit gaps);
        queue_byte(b);
        crc = crc16_step(crc, b);
        if (gaps && tick_limit != 8'h00 && $urandom_range(99) < 10)
            queue_gap($urandom_range((tick_limit > 8'd8) ? 8 : int'(tick_limit), 1));
    endtask

    task automatic queue_frame(input logic [7:0] addr, input int unsigned len, input bit spoil,
                               input bit gaps, input int unsigned pause);
        logic [15:0] crc;
        logic [15:0] sent;
        logic [15:0] ln;
        crc = afr_pkg::CRC_INIT;
        ln  = len[15:0];
        queue_frame_byte(afr_pkg::FRAME_HEADER, crc, gaps);
        queue_frame_byte(addr, crc, gaps);
        queue_frame_byte(ln[15:8], crc, gaps);
        queue_frame_byte(ln[7:0], crc, gaps);
        for (int unsigned i = 0; i < len; i++)
        begin
            queue_frame_byte(8'($urandom_range(255)), crc, gaps);
            if (i == 0 && pause != 0)
                queue_gap(pause);
        end
        sent = spoil ? (crc ^ 16'($urandom_range(65535, 1))) : crc;
        queue_frame_byte(sent[15:8], crc, gaps);
        queue_byte(sent[7:0]);
    endtask

    task automatic queue_traffic(input int unsigned count);
        int unsigned start;
        int unsigned r;
        int unsigned len;
        logic [7:0]  addr;
        start = items_queued;
        while (items_queued - start < count)
        begin
            r = $urandom_range(99);
            if (r < 65 || tick_limit == afr_pkg::IDLE_MAX)
            begin
                addr = (tick_limit == afr_pkg::IDLE_MAX || $urandom_range(99) < 88) ?
                       own_addr : 8'($urandom_range(255));
                r    = $urandom_range(99);
                len  = (r < 60) ? $urandom_range(4) :
                       (r < 92) ? $urandom_range(16, 5) : $urandom_range(40, 17);
                queue_frame(addr, len, $urandom_range(99) < 25, 1'b1, 0);
            end
            else if (r < 77)
            begin
                queue_byte(afr_pkg::FRAME_HEADER);
                queue_byte(own_addr);
                repeat ($urandom_range(3))
                    queue_byte(8'($urandom_range(255)));
                queue_gap(int'(tick_limit) + 1);
            end
            else if (r < 90)
            begin
                repeat ($urandom_range(6, 1))
                    queue_byte(($urandom_range(3) == 0) ? afr_pkg::FRAME_HEADER
                                                        : 8'($urandom_range(255)));
                queue_gap(int'(tick_limit) + 1);
            end
            else
                queue_gap($urandom_range((tick_limit > 8'd10) ? 12 : int'(tick_limit) + 2, 1));
        end
        if (tick_limit != afr_pkg::IDLE_MAX)
            queue_gap(int'(tick_limit) + 1);
    endtask

    task automatic drain();
        while (items_taken != items_queued || awaited_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic load_registers(input logic [7:0] node, input logic [7:0] limit);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_NODE_ADDRESS;
        cfg_data  <= node;
        own_addr   = node;
        @(posedge clk);
        cfg_index <= REG_IDLE_LIMIT;
        cfg_data  <= limit;
        tick_limit = limit;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic start_hold();
        @(posedge clk);
        hold_req <= ~hold_req;
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values of the registers: node address 0, idle limit 3.
        queue_frame(8'h00, 0, 1'b1, 1'b0, 0);
        queue_frame(8'h00, 2, 1'b0, 1'b0, 0);
        queue_frame(8'h00, 1, 1'b1, 1'b0, 0);
        queue_byte(afr_pkg::FRAME_HEADER);
        queue_byte(afr_pkg::FRAME_HEADER);
        queue_byte(afr_pkg::FRAME_HEADER);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'hFF);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_gap(5);
        drain();

        load_registers(8'h00, 8'd3);
        queue_traffic(80);
        start_hold();
        drain();

        load_registers(8'hFF, 8'd0);
        @(posedge clk);
        steady <= 1'b1;
        @(negedge clk);
        queue_traffic(70);
        drain();
        @(posedge clk);
        steady <= 1'b0;
        @(negedge clk);

        load_registers(afr_pkg::FRAME_HEADER, afr_pkg::IDLE_MAX);
        queue_traffic(20);
        queue_frame(afr_pkg::FRAME_HEADER, 3, 1'b0, 1'b0, 260);
        queue_traffic(10);
        drain();

        load_registers(8'($urandom_range(255)), 8'($urandom_range(8, 1)));
        queue_frame(own_addr, 260, 1'b0, 1'b0, 0);
        queue_traffic(60);
        drain();

        load_registers(8'($urandom_range(255)), 8'd2);
        queue_traffic(80);
        start_hold();
        drain();

        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
